>>> sv/tsp_pkg.sv
`default_nettype none
package tsp_pkg;

  typedef enum logic [1:0] {
    FUNC_WRITE    = 2'd0,
    FUNC_POINT    = 2'd1,
    FUNC_BILINEAR = 2'd2
  } func_t;

  localparam logic REG_TEX_WIDTH  = 1'b0;
  localparam logic REG_TEX_HEIGHT = 1'b1;

  localparam int CFG_BITS   = 9;
  localparam int COORD_BITS = 24;
  localparam int LEVEL_BITS = 16;
  localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = 16'hFF00;

  typedef struct packed {
    logic do_write;
    logic do_sample;
  } op_t;

endpackage
`default_nettype wire

>>> sv/tsp_fifo.sv
`default_nettype none
module tsp_fifo import tsp_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] pop_data,
  output logic                  full,
  output logic                  empty
);
  localparam int AW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full && !pop |-> !push) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    empty |-> !pop) else $error("queue underflow");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH)) else $error("queue count out of range");

endmodule
`default_nettype wire

>>> sv/tsp_front.sv
`default_nettype none
module tsp_front import tsp_pkg::*; #(
  parameter int MAX_WIDTH   = 256,
  parameter int MAX_HEIGHT  = 256,
  parameter int WEIGHT_BITS = 8,
  parameter int XW          = 8,
  parameter int YW          = 8,
  parameter int EW          = 2 + 2 * XW + 2 * YW + 2 * WEIGHT_BITS + 24
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write,
  input  wire logic                  cfg_index,
  input  wire logic [CFG_BITS-1:0]   cfg_data,
  input  wire logic [1:0]            func,
  input  wire logic [COORD_BITS-1:0] coord_u,
  input  wire logic [COORD_BITS-1:0] coord_v,
  input  wire logic [7:0]            write_col,
  input  wire logic [7:0]            write_row,
  input  wire logic [7:0]            write_red,
  input  wire logic [7:0]            write_green,
  input  wire logic [7:0]            write_blue,
  output logic                       has_work,
  output logic [EW-1:0]              entry
);
  logic [CFG_BITS-1:0] tex_width;
  logic [CFG_BITS-1:0] tex_height;
  logic [CFG_BITS-1:0] eff_w;
  logic [CFG_BITS-1:0] eff_h;
  logic                is_point;
  logic [25:0]         pu;
  logic [25:0]         pv;
  logic [9:0]          iu1;
  logic [9:0]          iu2;
  logic [9:0]          iv1;
  logic [9:0]          iv2;
  logic [XW-1:0]       x1;
  logic [XW-1:0]       x2;
  logic [YW-1:0]       y1;
  logic [YW-1:0]       y2;
  logic [WEIGHT_BITS-1:0] fx;
  logic [WEIGHT_BITS-1:0] fy;
  op_t                 op;

  // Point samples clamp to 0..1; bilinear samples keep the fraction only.
  function automatic logic [25:0] scale(input logic [COORD_BITS-1:0] c,
                                        input logic [CFG_BITS-1:0] size,
                                        input logic pt);
    logic [16:0] opnd;
    if (pt) begin
      if (c[COORD_BITS-1]) begin
        opnd = '0;
      end else if (c[COORD_BITS-2:0] > 23'd65536) begin
        opnd = 17'h10000;
      end else begin
        opnd = c[16:0];
      end
    end else begin
      opnd = {1'b0, c[15:0]};
    end
    return 26'(size) * 26'(opnd);
  endfunction

  function automatic logic [9:0] wrap_idx(input logic [9:0] i,
                                          input logic [CFG_BITS-1:0] size);
    return (i >= {1'b0, size}) ? '0 : i;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      tex_width  <= 9'd256;
      tex_height <= 9'd256;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_TEX_WIDTH:  tex_width  <= cfg_data;
        REG_TEX_HEIGHT: tex_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (tex_width == '0) eff_w = 9'd1;
    else if (32'(tex_width) > MAX_WIDTH) eff_w = 9'(MAX_WIDTH);
    else eff_w = tex_width;
    if (tex_height == '0) eff_h = 9'd1;
    else if (32'(tex_height) > MAX_HEIGHT) eff_h = 9'(MAX_HEIGHT);
    else eff_h = tex_height;
  end

  assign is_point = (func_t'(func) == FUNC_POINT);
  assign pu  = scale(coord_u, eff_w, is_point);
  assign pv  = scale(coord_v, eff_h, is_point);
  assign iu1 = wrap_idx(pu[25:16], eff_w);
  assign iv1 = wrap_idx(pv[25:16], eff_h);
  assign iu2 = wrap_idx(iu1 + 10'd1, eff_w);
  assign iv2 = wrap_idx(iv1 + 10'd1, eff_h);

  always_comb begin
    op = '0;
    x1 = XW'(iu1);
    x2 = XW'(iu2);
    y1 = YW'(iv1);
    y2 = YW'(iv2);
    fx = is_point ? '0 : pu[15 -: WEIGHT_BITS];
    fy = is_point ? '0 : pv[15 -: WEIGHT_BITS];
    case (func_t'(func))
      FUNC_WRITE: begin
        op.do_write = ({1'b0, write_col} < eff_w) && ({1'b0, write_row} < eff_h);
        x1 = XW'(write_col);
        y1 = YW'(write_row);
      end
      FUNC_POINT:    op.do_sample = 1'b1;
      FUNC_BILINEAR: op.do_sample = 1'b1;
      default: ;
    endcase
  end

  assign has_work = op.do_write || op.do_sample;
  assign entry = {op, x1, x2, y1, y2, fx, fy, write_red, write_green, write_blue};

endmodule
`default_nettype wire

>>> sv/tsp_back.sv
`default_nettype none
module tsp_back import tsp_pkg::*; #(
  parameter int WEIGHT_BITS = 8,
  parameter int XW          = 8,
  parameter int YW          = 8,
  parameter int EW          = 2 + 2 * XW + 2 * YW + 2 * WEIGHT_BITS + 24
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  q_empty,
  input  wire logic [EW-1:0]         q_data,
  output logic                       q_pop,
  output logic                       clearing,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [LEVEL_BITS-1:0]      out_red,
  output logic [LEVEL_BITS-1:0]      out_green,
  output logic [LEVEL_BITS-1:0]      out_blue
);
  localparam int AW   = XW + YW;
  localparam int WB   = WEIGHT_BITS;
  localparam int QW   = 2 * WB + 2;
  localparam int PW   = QW + 8;
  localparam int SH   = 2 * WB - 8;
  localparam logic [PW-1:0] RND = (PW'(1) << SH) >> 1;
  localparam logic [WB:0]   ONE = (WB + 1)'(1) << WB;

  op_t           e_op;
  logic [XW-1:0] e_x1;
  logic [XW-1:0] e_x2;
  logic [YW-1:0] e_y1;
  logic [YW-1:0] e_y2;
  logic [WB-1:0] e_fx;
  logic [WB-1:0] e_fy;
  logic [23:0]   e_rgb;

  logic [23:0]   mem_a [2**AW];
  logic [23:0]   mem_b [2**AW];
  logic [AW-1:0] clr_addr;
  logic          mem_we;
  logic [AW-1:0] waddr;
  logic [23:0]   wdata;
  logic          adv;

  logic [WB:0]   nfx;
  logic [WB:0]   nfy;
  logic [23:0]   tex1 [4];
  logic [QW-1:0] wgt1 [4];
  logic          v1;
  logic [PW-1:0] prod2 [3][4];
  logic          v2;
  logic [PW-1:0] sum3 [3];

  assign {e_op, e_x1, e_x2, e_y1, e_y2, e_fx, e_fy, e_rgb} = q_data;

  assign adv   = !out_valid || out_ready;
  assign q_pop = adv && !q_empty && !clearing;

  // Reset walks every address once, zeroing both copies of the store.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == '1) begin
        clearing <= 1'b0;
      end
    end
  end

  assign mem_we = clearing || (q_pop && e_op.do_write);
  assign waddr  = clearing ? clr_addr : {e_y1, e_x1};
  assign wdata  = clearing ? '0 : e_rgb;

  // Two copies of the store, each with two read ports, serve the four neighbors.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_a[waddr] <= wdata;
      mem_b[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      tex1[0] <= mem_a[{e_y1, e_x1}];
      tex1[1] <= mem_a[{e_y1, e_x2}];
      tex1[2] <= mem_b[{e_y2, e_x1}];
      tex1[3] <= mem_b[{e_y2, e_x2}];
    end
  end

  assign nfx = ONE - {1'b0, e_fx};
  assign nfy = ONE - {1'b0, e_fy};

  always_ff @(posedge clk) begin
    if (adv) begin
      wgt1[0] <= QW'(nfx) * QW'(nfy);
      wgt1[1] <= QW'({1'b0, e_fx}) * QW'(nfy);
      wgt1[2] <= QW'(nfx) * QW'({1'b0, e_fy});
      wgt1[3] <= QW'({1'b0, e_fx}) * QW'({1'b0, e_fy});
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int ch = 0; ch < 3; ch++) begin
        for (int k = 0; k < 4; k++) begin
          prod2[ch][k] <= PW'(tex1[k][23 - 8 * ch -: 8]) * PW'(wgt1[k]);
        end
      end
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      sum3[ch] = prod2[ch][0] + prod2[ch][1] + prod2[ch][2] + prod2[ch][3] + RND;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_red   <= sum3[0][SH +: LEVEL_BITS];
      out_green <= sum3[1][SH +: LEVEL_BITS];
      out_blue  <= sum3[2][SH +: LEVEL_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= q_pop && e_op.do_sample;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  a_no_pop_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !q_pop) else $error("item taken during store clear");
  a_clear_done: assert property (@(posedge clk) disable iff (rst)
    $fell(clearing) |-> $past(clr_addr) == '1) else $error("store clear cut short");
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_red <= LEVEL_MAX) && (out_green <= LEVEL_MAX)
                  && (out_blue <= LEVEL_MAX)) else $error("level above full scale");
  a_pipe_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> (v1 == $past(v1)) && (v2 == $past(v2))) else $error("pipeline moved on stall");

endmodule
`default_nettype wire

>>> sv/texture_sampler_point_bilinear.sv
// Texture sampler over an RGB8 texel store, with point and bilinear modes.
// Input channel (in_valid/in_ready): one word per item. func selects a texel
// write (no result), a point sample or a bilinear sample (one result each).
// Output channel (out_valid/out_ready): one word per sample with red, green
// and blue levels in Q8.8, where 65280 is full intensity.
// Configuration: cfg_write with cfg_index 0 sets the width and index 1 the
// height in use; write only while the block is idle.
// Throughput is one item per cycle while the receiver keeps out_ready high. An
// accepted item passes through the queue, then through registered stages: the
// store read with the weight products, the texel-weight products, the blend sum.
// Writes take effect before any later sample reads the store.
// After reset the block clears the store, one address per cycle, covering
// MAX_WIDTH*MAX_HEIGHT addresses (rounded up to powers of two); in_ready stays
// low meanwhile. A stalled receiver halts the back pipeline; the four-entry
// queue keeps taking words until it fills, then in_ready drops.
`default_nettype none
module texture_sampler_point_bilinear import tsp_pkg::*; #(
  parameter int MAX_WIDTH   = 256,
  parameter int MAX_HEIGHT  = 256,
  parameter int WEIGHT_BITS = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write,
  input  wire logic                  cfg_index,
  input  wire logic [CFG_BITS-1:0]   cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [1:0]            func,
  input  wire logic [COORD_BITS-1:0] coord_u,
  input  wire logic [COORD_BITS-1:0] coord_v,
  input  wire logic [7:0]            write_col,
  input  wire logic [7:0]            write_row,
  input  wire logic [7:0]            write_red,
  input  wire logic [7:0]            write_green,
  input  wire logic [7:0]            write_blue,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [LEVEL_BITS-1:0]      out_red,
  output logic [LEVEL_BITS-1:0]      out_green,
  output logic [LEVEL_BITS-1:0]      out_blue
);
  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int EW = 2 + 2 * XW + 2 * YW + 2 * WEIGHT_BITS + 24;

  logic          has_work;
  logic [EW-1:0] entry;
  logic [EW-1:0] q_data;
  logic          q_full;
  logic          q_empty;
  logic          q_pop;
  logic          clearing;

  assign in_ready = !q_full && !clearing;

  tsp_front #(
    .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .WEIGHT_BITS(WEIGHT_BITS),
    .XW(XW), .YW(YW), .EW(EW)
  ) u_front (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data,
    .func, .coord_u, .coord_v, .write_col, .write_row,
    .write_red, .write_green, .write_blue,
    .has_work, .entry
  );

  tsp_fifo #(.WIDTH(EW), .DEPTH(4)) u_fifo (
    .clk, .rst,
    .push(in_valid && in_ready && has_work),
    .push_data(entry),
    .pop(q_pop),
    .pop_data(q_data),
    .full(q_full),
    .empty(q_empty)
  );

  tsp_back #(
    .WEIGHT_BITS(WEIGHT_BITS), .XW(XW), .YW(YW), .EW(EW)
  ) u_back (
    .clk, .rst, .q_empty, .q_data, .q_pop, .clearing,
    .out_valid, .out_ready, .out_red, .out_green, .out_blue
  );

endmodule
`default_nettype wire
